/* src/lavb_pkg.sv */
// Shared widths, limits and the side-band beat record of the look-at basis pipeline.
// No dependencies; every other file imports this package.
package lavb_pkg;

  localparam int DW    = 16;         // component width
  localparam int FB    = 14;         // fraction bits
  localparam int CW    = 2 * DW + 1; // cross product width, signed
  localparam int MAGW  = 2 * DW;     // cross product magnitude width
  localparam int MW    = 30;         // normalized magnitude width
  localparam int NTOP  = MW - 1;     // leading one position after normalization
  localparam int LZW   = 6;          // leading zero count width
  localparam int SQW   = 2 * MW;     // square width
  localparam int SUMW  = SQW + 2;    // sum of three squares
  localparam int ACCW  = SUMW + 1;   // square root working width
  localparam int RTW   = SUMW / 2;   // root width
  localparam int QW    = DW;         // quotient width
  localparam int NUMW  = MW + FB + 1;// rounded dividend width
  localparam int PW    = 2 * DW;     // product width

  localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic                   degen;
    logic [2:0]             neg;
    logic [2:0][DW-1:0]     d;
    logic [2:0][DW-1:0]     back;
    logic [2:0][MW-1:0]     m;
  } carry_t;

endpackage

/* src/lavb_front.sv */
// Front pipeline: cross product, magnitudes, normalization and sum of squares.
// Depends on lavb_pkg.
module lavb_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [2:0][lavb_pkg::DW-1:0]       dir_i,
  input  logic [2:0][lavb_pkg::DW-1:0]       up_i,
  output logic                               valid_o,
  output logic [lavb_pkg::SUMW-1:0]          sum_o,
  output lavb_pkg::carry_t                   carry_o
);
  import lavb_pkg::*;

  logic                    v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic signed [PW-1:0]    p1_d [6];
  logic signed [PW-1:0]    p1_q [6];
  carry_t                  k1_d, k1_q, k2_d, k2_q, k3_q, k4_d, k4_q, k5_q, k6_q;
  logic signed [CW-1:0]    c2 [3];
  logic [MAGW-1:0]         mag2_d [3];
  logic [MAGW-1:0]         mag2_q [3];
  logic [MAGW-1:0]         mag3_q [3];
  logic [MAGW-1:0]         big;
  logic [LZW-1:0]          lz3_d, lz3_q;
  logic [SQW-1:0]          sq5_d [3];
  logic [SQW-1:0]          sq5_q [3];
  logic [SUMW-1:0]         sum6_q;

  // stage 1: six products, negated direction
  always_comb begin
    p1_d[0] = $signed(dir_i[1]) * $signed(up_i[2]);
    p1_d[1] = $signed(dir_i[2]) * $signed(up_i[1]);
    p1_d[2] = $signed(dir_i[2]) * $signed(up_i[0]);
    p1_d[3] = $signed(dir_i[0]) * $signed(up_i[2]);
    p1_d[4] = $signed(dir_i[0]) * $signed(up_i[1]);
    p1_d[5] = $signed(dir_i[1]) * $signed(up_i[0]);
    k1_d = '0;
    k1_d.d = dir_i;
    for (int i = 0; i < 3; i++) begin
      k1_d.back[i] = (dir_i[i] == DMIN) ? DMAX : ~dir_i[i] + DW'(1);
    end
  end

  // stage 2: differences, sign and magnitude
  always_comb begin
    c2[0] = CW'(p1_q[0]) - CW'(p1_q[1]);
    c2[1] = CW'(p1_q[2]) - CW'(p1_q[3]);
    c2[2] = CW'(p1_q[4]) - CW'(p1_q[5]);
    k2_d = k1_q;
    for (int i = 0; i < 3; i++) begin
      k2_d.neg[i] = c2[i][CW-1];
      mag2_d[i]   = c2[i][CW-1] ? MAGW'(-c2[i]) : MAGW'(c2[i]);
    end
    k2_d.degen = (mag2_d[0] == '0) && (mag2_d[1] == '0) && (mag2_d[2] == '0);
  end

  // stage 3: largest magnitude and its leading zero count
  always_comb begin
    big = mag2_q[0];
    if (mag2_q[1] > big) big = mag2_q[1];
    if (mag2_q[2] > big) big = mag2_q[2];
    lz3_d = LZW'(MAGW);
    for (int i = 0; i < MAGW; i++) begin
      if (big[i]) lz3_d = LZW'(MAGW - 1 - i);
    end
  end

  // stage 4: common shift that puts the largest at the top bit
  always_comb begin
    k4_d = k3_q;
    for (int i = 0; i < 3; i++) begin
      if (lz3_q >= LZW'(MAGW - 1 - NTOP)) begin
        k4_d.m[i] = MW'(mag3_q[i] << (lz3_q - LZW'(MAGW - 1 - NTOP)));
      end else begin
        k4_d.m[i] = MW'(mag3_q[i] >> (LZW'(MAGW - 1 - NTOP) - lz3_q));
      end
    end
  end

  // stage 5: squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq5_d[i] = SQW'(k4_q.m[i]) * SQW'(k4_q.m[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q   <= p1_d;
    k1_q   <= k1_d;
    mag2_q <= mag2_d;
    k2_q   <= k2_d;
    mag3_q <= mag2_q;
    lz3_q  <= lz3_d;
    k3_q   <= k2_q;
    k4_q   <= k4_d;
    sq5_q  <= sq5_d;
    k5_q   <= k4_q;
    sum6_q <= SUMW'(sq5_q[0]) + SUMW'(sq5_q[1]) + SUMW'(sq5_q[2]);
    k6_q   <= k5_q;
  end

  assign valid_o = v6_q;
  assign sum_o   = sum6_q;
  assign carry_o = k6_q;

endmodule

/* src/lavb_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on lavb_pkg.
module lavb_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [lavb_pkg::SUMW-1:0]    sum_i,
  input  lavb_pkg::carry_t             carry_i,
  output logic                         valid_o,
  output logic [lavb_pkg::RTW-1:0]     root_o,
  output lavb_pkg::carry_t             carry_o
);
  import lavb_pkg::*;

  localparam int STEPS = RTW;

  logic [ACCW-1:0] n_q [STEPS];
  logic [ACCW-1:0] r_q [STEPS];
  logic            v_q [STEPS];
  carry_t          k_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [ACCW-1:0] BIT = ACCW'(1) << (2 * (STEPS - 1 - k));
    logic [ACCW-1:0] n_in, r_in, trial;
    logic            v_in;
    carry_t          k_in;

    if (k == 0) begin : g_first
      assign n_in = ACCW'(sum_i);
      assign r_in = '0;
      assign v_in = valid_i;
      assign k_in = carry_i;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
      assign v_in = v_q[k-1];
      assign k_in = k_q[k-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    // accept the trial bit when the remainder covers it
    always_ff @(posedge clk_i) begin
      if (n_in >= trial) begin
        n_q[k] <= n_in - trial;
        r_q[k] <= (r_in >> 1) + BIT;
      end else begin
        n_q[k] <= n_in;
        r_q[k] <= r_in >> 1;
      end
      k_q[k] <= k_in;
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign root_o  = r_q[STEPS-1][RTW-1:0];
  assign carry_o = k_q[STEPS-1];

endmodule

/* src/lavb_div.sv */
// Three-lane pipelined restoring divider: rounded |c| * 2^FB / length.
// Depends on lavb_pkg.
module lavb_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [lavb_pkg::RTW-1:0]       len_i,
  input  lavb_pkg::carry_t               carry_i,
  output logic                           valid_o,
  output logic [2:0][lavb_pkg::QW-1:0]   quo_o,
  output lavb_pkg::carry_t               carry_o
);
  import lavb_pkg::*;

  localparam int STEPS = QW;

  logic [NUMW-1:0]        num [3];
  logic                   v0_q;
  logic [RTW-1:0]         len0_q;
  logic [2:0][RTW-1:0]    rem0_q;
  logic [2:0][QW-1:0]     low0_q;
  carry_t                 k0_q;

  logic                   v_q   [STEPS];
  logic [RTW-1:0]         len_q [STEPS];
  logic [2:0][RTW-1:0]    rem_q [STEPS];
  logic [2:0][QW-1:0]     low_q [STEPS];
  logic [2:0][QW-1:0]     quo_q [STEPS];
  carry_t                 k_q   [STEPS];

  // setup: dividend with half the divisor added for rounding
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, carry_i.m[i], {FB{1'b0}}} + NUMW'(len_i >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    len0_q <= len_i;
    k0_q   <= carry_i;
    for (int i = 0; i < 3; i++) begin
      rem0_q[i] <= RTW'(num[i][NUMW-1:QW]);
      low0_q[i] <= num[i][QW-1:0];
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                v_in;
    logic [RTW-1:0]      len_in;
    logic [2:0][RTW-1:0] rem_in;
    logic [2:0][QW-1:0]  low_in;
    logic [2:0][QW-1:0]  quo_in;
    carry_t              k_in;
    logic [RTW:0]        t [3];
    logic [2:0]          ge;

    if (k == 0) begin : g_first
      assign v_in   = v0_q;
      assign len_in = len0_q;
      assign rem_in = rem0_q;
      assign low_in = low0_q;
      assign quo_in = '0;
      assign k_in   = k0_q;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign len_in = len_q[k-1];
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign k_in   = k_q[k-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {rem_in[i], low_in[i][QW-1]};
        ge[i] = (t[i] >= {1'b0, len_in});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      len_q[k] <= len_in;
      k_q[k]   <= k_in;
      for (int i = 0; i < 3; i++) begin
        rem_q[k][i] <= ge[i] ? RTW'(t[i] - {1'b0, len_in}) : RTW'(t[i]);
        low_q[k][i] <= {low_in[i][QW-2:0], 1'b0};
        quo_q[k][i] <= {quo_in[i][QW-2:0], ge[i]};
      end
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign quo_o   = quo_q[STEPS-1];
  assign carry_o = k_q[STEPS-1];

endmodule

/* src/lavb_back.sv */
// Back end: signed, saturated side vector, then true up = side x dir, rounded.
// Depends on lavb_pkg.
module lavb_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [2:0][lavb_pkg::QW-1:0]   quo_i,
  input  lavb_pkg::carry_t               carry_i,
  output logic                           valid_o,
  output logic [2:0][lavb_pkg::DW-1:0]   side_o,
  output logic [2:0][lavb_pkg::DW-1:0]   tu_o,
  output logic [2:0][lavb_pkg::DW-1:0]   back_o,
  output logic                           degen_o
);
  import lavb_pkg::*;

  localparam logic [QW:0] QLIM = {2'b01, {(QW-1){1'b0}}};

  logic                    v1_q, v2_q, v3_q;
  logic [2:0][DW-1:0]      side1_d, side1_q, side2_q, side3_q;
  carry_t                  k1_q, k2_q;
  logic [QW:0]             qc;
  logic signed [QW+1:0]    sv;
  logic signed [PW-1:0]    p2_d [6];
  logic signed [PW-1:0]    p2_q [6];
  logic signed [CW-1:0]    acc [3];
  logic signed [CW-FB-1:0] shr [3];
  logic [2:0][DW-1:0]      tu3_d, tu3_q;
  logic [2:0][DW-1:0]      back3_q;
  logic                    degen3_q;

  // stage 1: clamp quotient, apply sign, saturate
  always_comb begin
    qc = '0;
    sv = '0;
    for (int i = 0; i < 3; i++) begin
      qc = ({1'b0, quo_i[i]} > QLIM) ? QLIM : {1'b0, quo_i[i]};
      sv = carry_i.neg[i] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
      if (carry_i.degen) begin
        side1_d[i] = '0;
      end else if (sv > $signed((QW+2)'(DMAX))) begin
        side1_d[i] = DMAX;
      end else if (sv < -$signed((QW+2)'(QLIM))) begin
        side1_d[i] = DMIN;
      end else begin
        side1_d[i] = DW'(sv);
      end
    end
  end

  // stage 2: products for side x dir
  always_comb begin
    p2_d[0] = $signed(side1_q[1]) * $signed(k1_q.d[2]);
    p2_d[1] = $signed(side1_q[2]) * $signed(k1_q.d[1]);
    p2_d[2] = $signed(side1_q[2]) * $signed(k1_q.d[0]);
    p2_d[3] = $signed(side1_q[0]) * $signed(k1_q.d[2]);
    p2_d[4] = $signed(side1_q[0]) * $signed(k1_q.d[1]);
    p2_d[5] = $signed(side1_q[1]) * $signed(k1_q.d[0]);
  end

  // stage 3: difference, round half up, saturate
  always_comb begin
    acc[0] = CW'(p2_q[0]) - CW'(p2_q[1]) + CW'(1 << (FB - 1));
    acc[1] = CW'(p2_q[2]) - CW'(p2_q[3]) + CW'(1 << (FB - 1));
    acc[2] = CW'(p2_q[4]) - CW'(p2_q[5]) + CW'(1 << (FB - 1));
    for (int i = 0; i < 3; i++) begin
      shr[i] = acc[i][CW-1:FB];
      if (k2_q.degen) begin
        tu3_d[i] = '0;
      end else if (shr[i] > $signed((CW-FB)'(DMAX))) begin
        tu3_d[i] = DMAX;
      end else if (shr[i] < -$signed((CW-FB)'({1'b0, DMIN}))) begin
        tu3_d[i] = DMIN;
      end else begin
        tu3_d[i] = DW'(shr[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q  <= side1_d;
    k1_q     <= carry_i;
    p2_q     <= p2_d;
    side2_q  <= side1_q;
    k2_q     <= k1_q;
    side3_q  <= side2_q;
    tu3_q    <= tu3_d;
    back3_q  <= k2_q.back;
    degen3_q <= k2_q.degen;
  end

  assign valid_o = v3_q;
  assign side_o  = side3_q;
  assign tu_o    = tu3_q;
  assign back_o  = back3_q;
  assign degen_o = degen3_q;

endmodule

/* src/look_at_view_basis_top.sv */
// Look-at view basis: rotation rows of a view matrix from a direction and an up vector.
// Depends on lavb_pkg, lavb_front, lavb_sqrt, lavb_div and lavb_back.
//
// Usage:
//   Drive dir_*_i and up_*_i (signed Q2.14) and raise start_i; the beat is taken
//   at any rising edge with start_i high and busy_o low. busy_o never rises, so
//   a new beat can enter on every cycle.
//   Each beat returns one result beat on side_*_o, true_up_*_o, back_*_o and
//   degenerate_o, marked by valid_o for a single cycle. Results leave in the
//   order the beats came in.
//   The path runs through cross product, normalization and squares, then square
//   root (one root bit per stage), division (setup plus one quotient bit per
//   stage, three lanes side by side), and last signing, true-up products and
//   rounding.
//   Throughput is one beat per cycle; the deepest stage is a 63-bit compare and
//   subtract in the square root.
//   When the cross product is zero, degenerate_o is set and the side and true
//   up rows read zero; the back row is still the negated direction.
//   Reset clears every valid bit in the pipe, so beats in flight are dropped
//   and valid_o stays low until new beats arrive.
//   The receiver has no way to stall: a result is present for one cycle only.
module look_at_view_basis_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [lavb_pkg::DW-1:0]   dir_x_i,
  input  logic [lavb_pkg::DW-1:0]   dir_y_i,
  input  logic [lavb_pkg::DW-1:0]   dir_z_i,
  input  logic [lavb_pkg::DW-1:0]   up_x_i,
  input  logic [lavb_pkg::DW-1:0]   up_y_i,
  input  logic [lavb_pkg::DW-1:0]   up_z_i,
  output logic                      valid_o,
  output logic [lavb_pkg::DW-1:0]   side_x_o,
  output logic [lavb_pkg::DW-1:0]   side_y_o,
  output logic [lavb_pkg::DW-1:0]   side_z_o,
  output logic [lavb_pkg::DW-1:0]   true_up_x_o,
  output logic [lavb_pkg::DW-1:0]   true_up_y_o,
  output logic [lavb_pkg::DW-1:0]   true_up_z_o,
  output logic [lavb_pkg::DW-1:0]   back_x_o,
  output logic [lavb_pkg::DW-1:0]   back_y_o,
  output logic [lavb_pkg::DW-1:0]   back_z_o,
  output logic                      degenerate_o
);
  import lavb_pkg::*;

  logic               accept;
  logic [2:0][DW-1:0] dir, up;
  logic               f_valid, s_valid, d_valid;
  logic [SUMW-1:0]    f_sum;
  carry_t             f_carry, s_carry, d_carry;
  logic [RTW-1:0]     s_root;
  logic [2:0][QW-1:0] d_quo;
  logic [2:0][DW-1:0] side, tu, back;

  // the pipe never holds off a beat
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign dir = {dir_z_i, dir_y_i, dir_x_i};
  assign up  = {up_z_i, up_y_i, up_x_i};

  lavb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .dir_i   (dir),
    .up_i    (up),
    .valid_o (f_valid),
    .sum_o   (f_sum),
    .carry_o (f_carry)
  );

  lavb_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .sum_i   (f_sum),
    .carry_i (f_carry),
    .valid_o (s_valid),
    .root_o  (s_root),
    .carry_o (s_carry)
  );

  lavb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .len_i   (s_root),
    .carry_i (s_carry),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .carry_o (d_carry)
  );

  lavb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .quo_i   (d_quo),
    .carry_i (d_carry),
    .valid_o (valid_o),
    .side_o  (side),
    .tu_o    (tu),
    .back_o  (back),
    .degen_o (degenerate_o)
  );

  // unpack rows onto their ports
  assign side_x_o    = side[0];
  assign side_y_o    = side[1];
  assign side_z_o    = side[2];
  assign true_up_x_o = tu[0];
  assign true_up_y_o = tu[1];
  assign true_up_z_o = tu[2];
  assign back_x_o    = back[0];
  assign back_y_o    = back[1];
  assign back_z_o    = back[2];

endmodule
